// File: rtl/lcdcur_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdcur_pkg
// Types, codes and constants shared by the character LCD cursor controller.
// ----------------------------------------------------------------------------
package lcdcur_pkg;

  // Item command codes.
  typedef enum logic [1:0] {
    CMD_PUT  = 2'd0,
    CMD_GOTO = 2'd1,
    CMD_INIT = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  // Control characters handled by a put, and the blank that a backspace writes.
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_BLANK = 8'h20;

  // Set-address instruction opcode.
  localparam logic [7:0] SET_ADDR = 8'h80;

  // Number of instruction writes in the power-up sequence.
  localparam int INIT_LEN = 6;

  // Width of the write sequencer step counter.
  localparam int STEP_W = 3;

  // Depth of the job queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Kinds of jobs that the back end carries out.
  typedef enum logic [1:0] {
    JOB_ADDR  = 2'd0,  // set-address write only
    JOB_PRINT = 2'd1,  // data write, then set-address write
    JOB_BKSP  = 2'd2,  // set-address, blank data write, set-address
    JOB_INIT  = 2'd3   // power-up instruction sequence
  } job_kind_t;

  // One job handed from the front end to the back end.
  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] char_code;
    logic [7:0] addr;
  } job_t;

  // One bus word toward the display controller.
  typedef struct packed {
    logic       to_data_register;
    logic [7:0] bus_byte;
    logic       last_write;
  } write_t;

  // Instruction bytes of the power-up sequence, by step.
  function automatic logic [7:0] init_byte(input logic [STEP_W-1:0] step);
    logic [7:0] b;
    unique case (step)
      3'd0:    b = 8'h34;
      3'd1:    b = 8'h09;
      3'd2:    b = 8'h30;
      3'd3:    b = 8'h0F;
      3'd4:    b = 8'h01;
      3'd5:    b = 8'h06;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// File: rtl/lcdcur_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdcur_front
// Accepts items, keeps the cursor row and column, and turns each item into a
// job with the bytes that the back end needs.
// ----------------------------------------------------------------------------
module lcdcur_front
  import lcdcur_pkg::*;
#(
  parameter int COLUMNS       = 20,
  parameter int ROWS          = 4,
  parameter int ROW_ADDR_STEP = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire logic [1:0] cmd,
  input  wire logic [7:0] char_code,
  input  wire logic [7:0] row,
  input  wire logic [7:0] column,
  input  wire logic       q_full,
  output logic            push,
  output job_t            push_job
);

  localparam int COL_W    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int HALF_COL = COLUMNS / 2;
  localparam int ADDR_W   = 9;

  logic [ROW_W-1:0] cur_row;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row_next;
  logic [COL_W-1:0] cur_col_next;
  logic [ROW_W-1:0] row_inc;
  logic             accept;
  job_kind_t        kind;

  // Constant division tables for the go-to reduction of 8-bit inputs.
  logic [COL_W-1:0] col_rem_tbl [256];
  logic [ROW_W-1:0] col_quo_tbl [256];
  logic [ROW_W-1:0] row_mod_tbl [256];

  for (genvar i = 0; i < 256; i++) begin : g_tbl
    assign col_rem_tbl[i] = COL_W'(i % COLUMNS);
    assign col_quo_tbl[i] = ROW_W'((i / COLUMNS) % ROWS);
    assign row_mod_tbl[i] = ROW_W'(i % ROWS);
  end

  logic [ROW_W:0]        goto_sum;
  logic [ROW_W-1:0]      goto_row;
  logic [ADDR_W-1:0]     addr_sum;

  // The front accepts whenever the queue has room.
  assign item_stall = q_full;
  assign accept     = item_valid && !q_full;
  assign push       = accept && (cmd_t'(cmd) != CMD_NONE);

  // Next row with wrap from the last row to the first.
  assign row_inc = (cur_row == ROW_W'(ROWS - 1)) ? '0 : cur_row + 1'b1;

  // Go-to row: both terms are reduced modulo ROWS, so one subtract suffices.
  assign goto_sum = {1'b0, row_mod_tbl[row]} + {1'b0, col_quo_tbl[column]};
  assign goto_row = (goto_sum >= (ROW_W + 1)'(ROWS)) ?
                    ROW_W'(goto_sum - (ROW_W + 1)'(ROWS)) : goto_sum[ROW_W-1:0];

  // Cursor update and job selection for the current item.
  always_comb begin
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    kind         = JOB_ADDR;
    unique case (cmd_t'(cmd))
      CMD_INIT: begin
        cur_row_next = '0;
        cur_col_next = '0;
        kind         = JOB_INIT;
      end
      CMD_GOTO: begin
        cur_row_next = goto_row;
        cur_col_next = col_rem_tbl[column];
      end
      CMD_PUT: begin
        priority if (char_code == CHAR_CR) begin
          cur_row_next = row_inc;
          cur_col_next = '0;
        end else if (char_code == CHAR_BS) begin
          if (cur_col != '0) begin
            cur_col_next = cur_col - 1'b1;
            kind         = JOB_BKSP;
          end
        end else if (char_code == CHAR_TAB) begin
          priority if ((cur_row == ROW_W'(ROWS - 1)) &&
                       (cur_col >= COL_W'(HALF_COL))) begin
            cur_row_next = '0;
            cur_col_next = '0;
          end else if (cur_col < COL_W'(HALF_COL)) begin
            cur_col_next = COL_W'(HALF_COL);
          end else begin
            cur_row_next = row_inc;
            cur_col_next = '0;
          end
        end else begin
          kind = JOB_PRINT;
          if (cur_col == COL_W'(COLUMNS - 1)) begin
            cur_row_next = row_inc;
            cur_col_next = '0;
          end else begin
            cur_col_next = cur_col + 1'b1;
          end
        end
      end
      CMD_NONE: begin
        kind = JOB_ADDR;
      end
      default: begin
        kind = JOB_ADDR;
      end
    endcase
  end

  // Set-address byte of the new cursor position.
  assign addr_sum = ADDR_W'(cur_row_next) * ADDR_W'(ROW_ADDR_STEP) + ADDR_W'(cur_col_next);

  always_comb begin
    push_job.kind      = kind;
    push_job.char_code = char_code;
    push_job.addr      = SET_ADDR | addr_sum[7:0];
  end

  // Cursor registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row <= '0;
      cur_col <= '0;
    end else if (accept) begin
      cur_row <= cur_row_next;
      cur_col <= cur_col_next;
    end
  end

  // The cursor always stays on the display.
  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    (cur_col <= COL_W'(COLUMNS - 1)) && (cur_row <= ROW_W'(ROWS - 1)))
    else $error("cursor left the display area");

endmodule
`default_nettype wire

// File: rtl/lcdcur_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdcur_queue
// Short job queue that decouples the front end from the write sequencer.
// ----------------------------------------------------------------------------
module lcdcur_queue
  import lcdcur_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output logic      head_valid,
  output job_t      head,
  output logic      full
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head_valid = (count != '0);
  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head       = entries[rd_ptr];

  // Storage write; the front never pushes into a full queue.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("job queue holds more words than its depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("job popped from an empty queue");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    full && !pop |-> !push)
    else $error("job pushed into a full queue");

endmodule
`default_nettype wire

// File: rtl/lcdcur_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdcur_back
// Write sequencer: expands the job at the queue head into bus words, one per
// cycle while write_stall is low, through a registered output stage.
// ----------------------------------------------------------------------------
module lcdcur_back
  import lcdcur_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  head_valid,
  input  wire job_t  head,
  output logic       pop,
  output logic       write_valid,
  input  wire logic  write_stall,
  output logic       to_data_register,
  output logic [7:0] bus_byte,
  output logic       last_write
);

  logic [STEP_W-1:0] step;
  write_t            gen;
  write_t            out_word;
  logic              load;

  // Bus word for the current step of the head job.
  always_comb begin
    gen.to_data_register = 1'b0;
    gen.bus_byte         = head.addr;
    gen.last_write       = 1'b1;
    unique case (head.kind)
      JOB_ADDR: begin
        gen.last_write = 1'b1;
      end
      JOB_PRINT: begin
        if (step == 3'd0) begin
          gen.to_data_register = 1'b1;
          gen.bus_byte         = head.char_code;
          gen.last_write       = 1'b0;
        end
      end
      JOB_BKSP: begin
        if (step == 3'd0) begin
          gen.last_write = 1'b0;
        end else if (step == 3'd1) begin
          gen.to_data_register = 1'b1;
          gen.bus_byte         = CHAR_BLANK;
          gen.last_write       = 1'b0;
        end
      end
      JOB_INIT: begin
        gen.bus_byte   = init_byte(step);
        gen.last_write = (step == STEP_W'(INIT_LEN - 1));
      end
      default: begin
        gen.last_write = 1'b1;
      end
    endcase
  end

  // A word of the head job moves into the output register whenever one is waiting and the register is empty or drains.
  assign load = head_valid && (!write_valid || !write_stall);
  assign pop  = load && gen.last_write;

  // Step counter and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      step        <= '0;
      write_valid <= 1'b0;
    end else begin
      if (load) begin
        step        <= gen.last_write ? '0 : step + 1'b1;
        write_valid <= 1'b1;
      end else if (!write_stall) begin
        write_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= gen;
    end
  end

  assign to_data_register = out_word.to_data_register;
  assign bus_byte         = out_word.bus_byte;
  assign last_write       = out_word.last_write;

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    step <= STEP_W'(INIT_LEN - 1))
    else $error("write step ran past the longest job");

  a_step_restart: assert property (@(posedge clk) disable iff (rst)
    pop |=> step == '0)
    else $error("step counter did not restart after the final word");

  a_short_job_step: assert property (@(posedge clk) disable iff (rst)
    head_valid && (head.kind != JOB_INIT) |-> step <= 3'd2)
    else $error("step out of range for a short job");

endmodule
`default_nettype wire

// File: rtl/text_lcd_cursor_controller_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_lcd_cursor_controller_top
// Cursor controller for a character LCD: takes put, go-to and initialise
// items and issues the resulting display bus writes in order.
// ----------------------------------------------------------------------------
// The block takes one item per cycle while its two-entry job queue has room,
// and sends one bus word per cycle while write_stall is low. The write
// sequencer sets the sustained rate: a printable character sends two bus
// words, a backspace away from column 0 sends three, initialise sends six,
// and every other put or go-to sends one; an unused command is accepted and
// sends nothing. The cursor is updated when the item is accepted, so an item
// never waits on the cursor result of an earlier one; items wait only while
// the job queue is full. No clearing pass is needed after reset.
module text_lcd_cursor_controller_top
  import lcdcur_pkg::*;
#(
  parameter int COLUMNS       = 20,
  parameter int ROWS          = 4,
  parameter int ROW_ADDR_STEP = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire logic [1:0] cmd,
  input  wire logic [7:0] char_code,
  input  wire logic [7:0] row,
  input  wire logic [7:0] column,
  output logic            write_valid,
  input  wire logic       write_stall,
  output logic            to_data_register,
  output logic [7:0]      bus_byte,
  output logic            last_write
);

  logic push;
  job_t push_job;
  logic pop;
  logic head_valid;
  job_t head;
  logic q_full;

  // Front end: cursor tracking and job selection.
  lcdcur_front #(
    .COLUMNS       (COLUMNS),
    .ROWS          (ROWS),
    .ROW_ADDR_STEP (ROW_ADDR_STEP)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .cmd        (cmd),
    .char_code  (char_code),
    .row        (row),
    .column     (column),
    .q_full     (q_full),
    .push       (push),
    .push_job   (push_job)
  );

  // Job queue between the two halves.
  lcdcur_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .full       (q_full)
  );

  // Back end: bus word sequencer.
  lcdcur_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head_valid       (head_valid),
    .head             (head),
    .pop              (pop),
    .write_valid      (write_valid),
    .write_stall      (write_stall),
    .to_data_register (to_data_register),
    .bus_byte         (bus_byte),
    .last_write       (last_write)
  );

endmodule
`default_nettype wire
